// ----- src/gwsc_pkg.sv -----
// Package for the grid word search counter.
// Holds character and count types, register indexes, reset values and the word compare.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package gwsc_pkg;

  // Basic widths of the item and result fields.
  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // A word has four letters, so a match reaches three cells back.
  localparam int REACH      = 3;
  localparam int MIN_WIDTH  = 4;
  localparam int SLOT_CNT   = 3;

  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [1:0]            slot_t;
  typedef logic [1:0]            pair_cnt_t;
  typedef logic [3:0]            found_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH     = 3'd0,
    CFG_FIRST_LETTER  = 3'd1,
    CFG_SECOND_LETTER = 3'd2,
    CFG_THIRD_LETTER  = 3'd3,
    CFG_FOURTH_LETTER = 3'd4
  } cfg_idx_t;

  // Reset values of the registers: a row of 256 and the word XMAS.
  localparam cfg_data_t ROW_WIDTH_RST = 9'd256;
  localparam char_t     LETTER0_RST   = 8'd88;
  localparam char_t     LETTER1_RST   = 8'd77;
  localparam char_t     LETTER2_RST   = 8'd65;
  localparam char_t     LETTER3_RST   = 8'd83;

  // Counts a placement forwards and reversed; a palindrome gives two.
  function automatic pair_cnt_t match_both(input char_t a, input char_t b,
                                           input char_t c, input char_t d,
                                           input char_t w0, input char_t w1,
                                           input char_t w2, input char_t w3);
    logic fwd;
    logic rev;
    fwd = (a == w0) && (b == w1) && (c == w2) && (d == w3);
    rev = (a == w3) && (b == w2) && (c == w1) && (d == w0);
    return pair_cnt_t'(fwd) + pair_cnt_t'(rev);
  endfunction

endpackage

`default_nettype wire

// ----- src/grid_word_search_counter_unit.sv -----
// Grid word search counter: counts a four-letter word in a streamed character grid.
// Depends on gwsc_pkg for types, register indexes, reset values and the word compare.
// The count of a grid is loaded into the result register as its last request is taken.
// Throughput: one character per cycle while in_stall is low; each of the three row
// memories serves one look-ahead read and at most one write per cycle, hence that rate.
// Reset: synchronous active-low rst_n clears the count, position and row state and loads
// the registers with a row width of 256 and the word XMAS; row memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module grid_word_search_counter_unit
  import gwsc_pkg::*;
#(
  parameter int MAX_WIDTH = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CHAR_W-1:0]    in_grid_char,
  input  wire logic                 in_last_in_grid,
  // Result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [COUNT_W-1:0]        out_match_count,
  // Configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CNT_W  = ADDR_W + 1;
  localparam int CW     = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
  localparam int TAPS   = 2 * REACH + 1;

  // Configuration registers.
  cfg_data_t row_width_r;
  char_t     letter_r [4];

  // Grid position and counting state.
  logic [ADDR_W-1:0] col_r;
  logic [ADDR_W-1:0] col_nxt;
  logic [23:0]       tail_r;
  logic [23:0]       tail_nxt;
  slot_t             rows_done_r;
  slot_t             rows_done_nxt;
  slot_t             oldest_r;
  slot_t             oldest_nxt;
  count_t            total_r;
  count_t            total_nxt;

  // Result register.
  logic   out_valid_r;
  count_t out_count_r;

  // Per-slot window of columns c-3..c+2, the look-ahead column c+3 and the row head.
  char_t win_r   [SLOT_CNT][TAPS-1];
  char_t ahead_r [SLOT_CNT];
  char_t head_r  [SLOT_CNT][4];
  char_t head_nxt [SLOT_CNT][4];
  char_t tap     [SLOT_CNT][TAPS];

  logic              in_acc;
  logic [CW-1:0]     rw_ext;
  logic [CNT_W-1:0]  eff_w;
  logic [CNT_W-1:0]  c_ext;
  logic [CNT_W-1:0]  ahead_sum;
  logic [ADDR_W-1:0] rd_addr;
  logic              row_end;
  logic              restart;
  logic              c_ge3;
  logic              diag_ok;
  logic              full_rows;
  slot_t             s1;
  slot_t             s2;
  slot_t             s3;
  char_t             r1 [TAPS];
  char_t             r2 [TAPS];
  char_t             r3 [TAPS];
  char_t             t1;
  char_t             t2;
  char_t             t3;
  found_t            found;
  logic [COUNT_W:0]  sum;

  // Handshakes: a new request waits only while a finished count is held back.
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_match_count = out_count_r;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
      letter_r[0] <= LETTER0_RST;
      letter_r[1] <= LETTER1_RST;
      letter_r[2] <= LETTER2_RST;
      letter_r[3] <= LETTER3_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROW_WIDTH:     row_width_r <= cfg_data;
        CFG_FIRST_LETTER:  letter_r[0] <= cfg_data[CHAR_W-1:0];
        CFG_SECOND_LETTER: letter_r[1] <= cfg_data[CHAR_W-1:0];
        CFG_THIRD_LETTER:  letter_r[2] <= cfg_data[CHAR_W-1:0];
        CFG_FOURTH_LETTER: letter_r[3] <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective row width, limited to MIN_WIDTH..MAX_WIDTH.
  always_comb begin
    rw_ext = CW'(row_width_r);
    if (rw_ext < CW'(MIN_WIDTH)) begin
      eff_w = CNT_W'(MIN_WIDTH);
    end else if (rw_ext > CW'(MAX_WIDTH)) begin
      eff_w = CNT_W'(MAX_WIDTH);
    end else begin
      eff_w = rw_ext[CNT_W-1:0];
    end
  end

  // Column tests and the look-ahead address, which wraps at MAX_WIDTH.
  always_comb begin
    c_ext     = {1'b0, col_r};
    c_ge3     = col_r >= ADDR_W'(REACH);
    diag_ok   = (c_ext + CNT_W'(REACH)) < eff_w;
    row_end   = (c_ext + CNT_W'(1)) >= eff_w;
    restart   = row_end || in_last_in_grid;
    full_rows = rows_done_r == slot_t'(SLOT_CNT);
    ahead_sum = c_ext + CNT_W'(REACH + 1);
    if (ahead_sum >= CNT_W'(MAX_WIDTH)) begin
      rd_addr = ADDR_W'(ahead_sum - CNT_W'(MAX_WIDTH));
    end else begin
      rd_addr = ahead_sum[ADDR_W-1:0];
    end
  end

  // Row roles: s3 is the oldest row and is overwritten by the current one.
  always_comb begin
    s3 = oldest_r;
    case (oldest_r)
      2'd0: begin
        s2 = 2'd1;
        s1 = 2'd2;
      end
      2'd1: begin
        s2 = 2'd2;
        s1 = 2'd0;
      end
      2'd2: begin
        s2 = 2'd0;
        s1 = 2'd1;
      end
      default: begin
        s2 = 2'd0;
        s1 = 2'd0;
      end
    endcase
  end

  // Per-slot storage: row memory, head registers and the sliding window.
  for (genvar s = 0; s < SLOT_CNT; s++) begin : g_slot
    char_t mem [MAX_WIDTH];
    logic  wr_en;

    assign wr_en = in_acc && (s3 == slot_t'(s));

    for (genvar i = 0; i < TAPS - 1; i++) begin : g_tap
      assign tap[s][i] = win_r[s][i];
    end
    assign tap[s][TAPS-1] = ahead_r[s];

    // The current row keeps its first four columns in registers as well.
    always_comb begin
      for (int k = 0; k < 4; k++) begin
        if (wr_en && (col_r == ADDR_W'(k))) begin
          head_nxt[s][k] = in_grid_char;
        end else begin
          head_nxt[s][k] = head_r[s][k];
        end
      end
    end

    always_ff @(posedge clk) begin
      head_r[s] <= head_nxt[s];
    end

    // Memory write of the current column and look-ahead read of column c+4.
    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[col_r] <= in_grid_char;
      end
      if (in_acc) begin
        if (restart) begin
          win_r[s][REACH]     <= head_nxt[s][0];
          win_r[s][REACH + 1] <= head_nxt[s][1];
          win_r[s][REACH + 2] <= head_nxt[s][2];
          ahead_r[s]          <= head_nxt[s][3];
        end else begin
          for (int i = 0; i < TAPS - 2; i++) begin
            win_r[s][i] <= win_r[s][i+1];
          end
          win_r[s][TAPS-2] <= ahead_r[s];
          ahead_r[s]       <= mem[rd_addr];
        end
      end
    end
  end

  // Windows of the three previous rows by role; tap REACH is column c.
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      r1[i] = tap[s1][i];
      r2[i] = tap[s2][i];
      r3[i] = tap[s3][i];
    end
  end

  // Eight placements end at this cell: row, column and the two diagonals, both ways.
  always_comb begin
    t1    = tail_r[7:0];
    t2    = tail_r[15:8];
    t3    = tail_r[23:16];
    found = '0;
    if (c_ge3) begin
      found = found + found_t'(match_both(t3, t2, t1, in_grid_char, letter_r[0],
                                          letter_r[1], letter_r[2], letter_r[3]));
    end
    if (full_rows) begin
      found = found + found_t'(match_both(r3[REACH], r2[REACH], r1[REACH], in_grid_char,
                                          letter_r[0], letter_r[1], letter_r[2],
                                          letter_r[3]));
      if (c_ge3) begin
        found = found + found_t'(match_both(r3[0], r2[1], r1[2], in_grid_char,
                                            letter_r[0], letter_r[1], letter_r[2],
                                            letter_r[3]));
      end
      if (diag_ok) begin
        found = found + found_t'(match_both(r3[6], r2[5], r1[4], in_grid_char,
                                            letter_r[0], letter_r[1], letter_r[2],
                                            letter_r[3]));
      end
    end
  end

  // Next position, row rotation and saturating total.
  always_comb begin
    sum = {1'b0, total_r} + (COUNT_W+1)'(found);
    if (row_end) begin
      col_nxt    = '0;
      tail_nxt   = '0;
      oldest_nxt = (oldest_r == slot_t'(SLOT_CNT - 1)) ? '0 : oldest_r + 2'd1;
      rows_done_nxt = full_rows ? rows_done_r : rows_done_r + 2'd1;
    end else begin
      col_nxt    = col_r + ADDR_W'(1);
      tail_nxt   = {tail_r[15:0], in_grid_char};
      oldest_nxt = oldest_r;
      rows_done_nxt = rows_done_r;
    end
    total_nxt = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  end

  // Grid state registers; the last request clears them for the next grid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      tail_r      <= '0;
      rows_done_r <= '0;
      oldest_r    <= '0;
      total_r     <= '0;
    end else if (in_acc) begin
      if (in_last_in_grid) begin
        col_r       <= '0;
        tail_r      <= '0;
        rows_done_r <= '0;
        oldest_r    <= '0;
        total_r     <= '0;
      end else begin
        col_r       <= col_nxt;
        tail_r      <= tail_nxt;
        rows_done_r <= rows_done_nxt;
        oldest_r    <= oldest_nxt;
        total_r     <= total_nxt;
      end
    end
  end

  // Result register: loaded by the last request, freed when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_last_in_grid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_last_in_grid) begin
      out_count_r <= total_nxt;
    end
  end

`ifndef SYNTHESIS
  // The last request leaves the grid state cleared.
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last_in_grid |=> col_r == '0 && total_r == '0 && rows_done_r == '0)
    else $error("grid state not cleared after last request");

  // A count appears only after a last request.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc && in_last_in_grid))
    else $error("result raised without a last request");

  // The running total never falls within a grid.
  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_last_in_grid |=> total_r >= $past(total_r))
    else $error("running total decreased");

  // Until three rows are done, the oldest slot pointer follows the row count.
  a_slot_tracks_rows: assert property (@(posedge clk) disable iff (!rst_n)
    rows_done_r != slot_t'(SLOT_CNT) |-> oldest_r == rows_done_r)
    else $error("row slot pointer out of step with completed rows");
`endif

endmodule

`default_nettype wire
